// File: rtl/core/fdr_pkg.sv
// Shared types and constants for the frame dirty-rectangle detector.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package fdr_pkg;

  localparam int COL_W      = 10;
  localparam int ROW_W      = 9;
  localparam int PIX_W      = 32;
  localparam int CNT_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_WIDTH = 2'd0,
    CFG_ACTIVE_ROWS  = 2'd1,
    CFG_FLIP_ROWS    = 2'd2
  } cfg_index_t;

  // effective (clamped) region settings
  typedef struct packed {
    logic [COL_W-1:0] eff_w;
    logic [ROW_W-1:0] eff_h;
    logic             flip;
  } cfg_t;

  // position of one pixel in destination coordinates
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] dst;
    logic             last;
  } pos_t;

  typedef struct packed {
    logic             changed;
    logic [COL_W-1:0] left;
    logic [ROW_W-1:0] top;
    logic [COL_W-1:0] right;
    logic [ROW_W-1:0] bottom;
    logic [CNT_W-1:0] number;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/core/fdr_if.sv
// Channel interfaces of the frame dirty-rectangle detector: pixel stream,
// result stream and register write port. Depends on fdr_pkg.
`default_nettype none

interface fdr_pix_if import fdr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] new_pixel;
  modport source (output valid, output new_pixel, input ready);
  modport sink (input valid, input new_pixel, output ready);
endinterface

interface fdr_res_if import fdr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             frame_changed;
  logic [COL_W-1:0] box_left;
  logic [ROW_W-1:0] box_top;
  logic [COL_W-1:0] box_right;
  logic [ROW_W-1:0] box_bottom;
  logic [CNT_W-1:0] frame_number;
  modport source (output valid, output frame_changed, output box_left, output box_top,
                  output box_right, output box_bottom, output frame_number, input ready);
  modport sink (input valid, input frame_changed, input box_left, input box_top,
                input box_right, input box_bottom, input frame_number, output ready);
endinterface

interface fdr_cfg_if import fdr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/fdr_frame_store.sv
// Previous-frame pixel store: one write port, one registered read port,
// and a clearing sweep after reset. Depends on fdr_pkg.
`default_nettype none

module fdr_frame_store import fdr_pkg::*; #(
  parameter int DEPTH = 307200,
  parameter int AW    = 19
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [PIX_W-1:0] rd_data,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [PIX_W-1:0] wr_data,
  output logic                  clearing
);

  logic [PIX_W-1:0] mem [DEPTH];
  logic [AW-1:0]    clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/fdr_addr_gen.sv
// Raster position counters and store address of the incoming pixel,
// with optional vertical flip. Depends on fdr_pkg.
`default_nettype none

module fdr_addr_gen import fdr_pkg::*; #(
  parameter int FRAME_WIDTH = 640,
  parameter int AW          = 19
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          restart,
  input  wire logic          accept,
  input  wire cfg_t          cfg,
  output pos_t               pos,
  output logic      [AW-1:0] addr
);

  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic             last_col;
  logic             last_row;

  always_comb begin
    last_col = (col == cfg.eff_w - 1'b1);
    last_row = (row == cfg.eff_h - 1'b1);
    pos.col  = col;
    pos.dst  = cfg.flip ? (cfg.eff_h - 1'b1 - row) : row;
    pos.last = last_col && last_row;
    addr     = AW'(AW'(pos.dst) * AW'(FRAME_WIDTH)) + AW'(col);
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (last_col) begin
        col <= '0;
        row <= last_row ? '0 : row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/fdr_box_acc.sv
// Compare stage: XOR against the stored pixel with same-address forwarding,
// write back, bounding-box accumulation and result register. Depends on fdr_pkg.
`default_nettype none

module fdr_box_acc import fdr_pkg::*; #(
  parameter int AW = 19
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             restart,
  input  wire logic             accept,
  input  wire pos_t             pos,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [PIX_W-1:0] new_pixel,
  input  wire logic [PIX_W-1:0] rd_data,
  output logic                  s1_adv,
  output logic                  wr_en,
  output logic      [AW-1:0]    wr_addr,
  output logic      [PIX_W-1:0] wr_data,
  output result_t               res,
  output logic                  res_valid,
  input  wire logic             res_ready
);

  logic             s1_valid;
  pos_t             s1_pos;
  logic [AW-1:0]    s1_addr;
  logic [PIX_W-1:0] s1_pixel;
  logic             fwd_hit;
  logic [PIX_W-1:0] fwd_data;
  logic             s1_fire;

  logic             any_diff;
  logic [COL_W-1:0] min_col, max_col;
  logic [ROW_W-1:0] min_row, max_row;
  logic [CNT_W-1:0] changed_count;

  logic             diff;
  logic             cur_any;
  logic [COL_W-1:0] cur_min_col, cur_max_col;
  logic [ROW_W-1:0] cur_min_row, cur_max_row;

  assign s1_adv  = !s1_valid || !(s1_pos.last && res_valid && !res_ready);
  assign s1_fire = s1_valid && s1_adv;
  assign wr_en   = s1_fire;
  assign wr_addr = s1_addr;
  assign wr_data = s1_pixel;

  always_comb begin
    diff        = (fwd_hit ? fwd_data : rd_data) != s1_pixel;
    cur_any     = any_diff || diff;
    cur_min_col = min_col;
    cur_max_col = max_col;
    cur_min_row = min_row;
    cur_max_row = max_row;
    if (diff && !any_diff) begin
      cur_min_col = s1_pos.col;
      cur_max_col = s1_pos.col;
      cur_min_row = s1_pos.dst;
      cur_max_row = s1_pos.dst;
    end else if (diff) begin
      if (s1_pos.col < min_col) cur_min_col = s1_pos.col;
      if (s1_pos.col > max_col) cur_max_col = s1_pos.col;
      if (s1_pos.dst < min_row) cur_min_row = s1_pos.dst;
      if (s1_pos.dst > max_row) cur_max_row = s1_pos.dst;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_adv) begin
      s1_valid <= accept;
    end
  end

  // forward the beat written at the same edge this read was issued
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pos   <= pos;
      s1_addr  <= addr;
      s1_pixel <= new_pixel;
      fwd_hit  <= s1_valid && (s1_addr == addr);
      fwd_data <= s1_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      changed_count <= '0;
    end else if (s1_fire && s1_pos.last && cur_any) begin
      changed_count <= changed_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart || (s1_fire && s1_pos.last)) begin
      any_diff <= 1'b0;
      min_col  <= '0;
      max_col  <= '0;
      min_row  <= '0;
      max_row  <= '0;
    end else if (s1_fire) begin
      any_diff <= cur_any;
      min_col  <= cur_min_col;
      max_col  <= cur_max_col;
      min_row  <= cur_min_row;
      max_row  <= cur_max_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_fire && s1_pos.last) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_pos.last) begin
      res.changed <= cur_any;
      res.left    <= cur_any ? cur_min_col : '0;
      res.top     <= cur_any ? cur_min_row : '0;
      res.right   <= cur_any ? cur_max_col : '0;
      res.bottom  <= cur_any ? cur_max_row : '0;
      res.number  <= changed_count;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/frame_dirty_rect_detect_unit.sv
// Frame dirty-rectangle detector: top level, register file and wiring.
// Depends on fdr_pkg, fdr_if, fdr_frame_store, fdr_addr_gen, fdr_box_acc.
//
// Takes one 32-bit pixel per clock in raster order over the active region and
// compares it with the pixel at the same destination position of the previous
// frame, held in an on-chip store of FRAME_WIDTH x FRAME_HEIGHT words with one
// read and one write port; the new pixel is written back over it. Pixels pass
// through two stages (address and read, then compare and write), and the store
// port pair sustains one pixel per cycle, including back-to-back frames. One
// result beat follows the last pixel of each frame, registered when that pixel
// leaves the compare stage, and sits in an output register while the next
// frame streams in; input stalls only while a frame's last pixel waits in the
// compare stage and the previous result is still untaken. After reset the
// store is cleared one word per cycle, all FRAME_WIDTH * FRAME_HEIGHT words
// (307200 at the defaults), during which no pixel is accepted; register writes
// are taken at any time and restart the frame.
`default_nettype none

module frame_dirty_rect_detect_unit import fdr_pkg::*; #(
  parameter int FRAME_WIDTH  = 640,
  parameter int FRAME_HEIGHT = 480
) (
  input wire logic  clk,
  input wire logic  rst,
  fdr_pix_if.sink   pixels,
  fdr_res_if.source results,
  fdr_cfg_if.sink   cfg
);

  localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [COL_W-1:0] active_width;
  logic [ROW_W-1:0] active_rows;
  logic             flip_rows;
  logic             restart;
  cfg_t             cfg_eff;

  logic             accept;
  logic             clearing;
  logic             s1_adv;
  pos_t             pos;
  logic [AW-1:0]    addr;
  logic [PIX_W-1:0] rd_data;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [PIX_W-1:0] wr_data;
  result_t          res;
  logic             res_valid;

  assign cfg.ready = 1'b1;

  always_comb begin
    restart = 1'b0;
    if (cfg.valid) begin
      case (cfg.index)
        CFG_ACTIVE_WIDTH, CFG_ACTIVE_ROWS, CFG_FLIP_ROWS: restart = 1'b1;
        default: restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_width <= COL_W'(640);
      active_rows  <= ROW_W'(480);
      flip_rows    <= 1'b1;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_ACTIVE_WIDTH: active_width <= cfg.data[COL_W-1:0];
        CFG_ACTIVE_ROWS:  active_rows  <= cfg.data[ROW_W-1:0];
        CFG_FLIP_ROWS:    flip_rows    <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // clamp: zero acts as one, oversize saturates at the store size
  always_comb begin
    if (active_width == '0) begin
      cfg_eff.eff_w = COL_W'(1);
    end else if (32'(active_width) > 32'(FRAME_WIDTH)) begin
      cfg_eff.eff_w = COL_W'(FRAME_WIDTH);
    end else begin
      cfg_eff.eff_w = active_width;
    end
    if (active_rows == '0) begin
      cfg_eff.eff_h = ROW_W'(1);
    end else if (32'(active_rows) > 32'(FRAME_HEIGHT)) begin
      cfg_eff.eff_h = ROW_W'(FRAME_HEIGHT);
    end else begin
      cfg_eff.eff_h = active_rows;
    end
    cfg_eff.flip = flip_rows;
  end

  assign pixels.ready = !clearing && s1_adv;
  assign accept       = pixels.valid && pixels.ready;

  fdr_addr_gen #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .AW          (AW)
  ) u_addr_gen (
    .clk     (clk),
    .rst     (rst),
    .restart (restart),
    .accept  (accept),
    .cfg     (cfg_eff),
    .pos     (pos),
    .addr    (addr)
  );

  fdr_frame_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept),
    .rd_addr  (addr),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .clearing (clearing)
  );

  fdr_box_acc #(
    .AW (AW)
  ) u_box_acc (
    .clk       (clk),
    .rst       (rst),
    .restart   (restart),
    .accept    (accept),
    .pos       (pos),
    .addr      (addr),
    .new_pixel (pixels.new_pixel),
    .rd_data   (rd_data),
    .s1_adv    (s1_adv),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (results.ready)
  );

  assign results.valid         = res_valid;
  assign results.frame_changed = res.changed;
  assign results.box_left      = res.left;
  assign results.box_top       = res.top;
  assign results.box_right     = res.right;
  assign results.box_bottom    = res.bottom;
  assign results.frame_number  = res.number;

endmodule

`default_nettype wire

// File: rtl/core/fdr_checker.sv
// Port-level checks of the frame dirty-rectangle detector, bound to the top
// level. Depends on fdr_pkg and frame_dirty_rect_detect_unit.
`default_nettype none

module fdr_checker import fdr_pkg::*; (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             pix_ready,
  input wire logic             res_valid,
  input wire logic             res_ready,
  input wire logic             frame_changed,
  input wire logic [COL_W-1:0] box_left,
  input wire logic [ROW_W-1:0] box_top,
  input wire logic [COL_W-1:0] box_right,
  input wire logic [ROW_W-1:0] box_bottom,
  input wire logic [CNT_W-1:0] frame_number
);

  // store clear holds off pixels right after reset
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !pix_ready)
    else $error("pixel ready during store clear");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(frame_changed) &&
      $stable(box_left) && $stable(box_top) && $stable(box_right) &&
      $stable(box_bottom) && $stable(frame_number))
    else $error("result beat changed while stalled");

  a_clean_box_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !frame_changed |->
      box_left == '0 && box_top == '0 && box_right == '0 && box_bottom == '0)
    else $error("unchanged frame with nonzero box");

  a_box_ordered: assert property (@(posedge clk) disable iff (rst)
    res_valid && frame_changed |-> box_left <= box_right && box_top <= box_bottom)
    else $error("box corners out of order");

endmodule

bind frame_dirty_rect_detect_unit fdr_checker u_fdr_checker (
  .clk           (clk),
  .rst           (rst),
  .pix_ready     (pixels.ready),
  .res_valid     (results.valid),
  .res_ready     (results.ready),
  .frame_changed (results.frame_changed),
  .box_left      (results.box_left),
  .box_top       (results.box_top),
  .box_right     (results.box_right),
  .box_bottom    (results.box_bottom),
  .frame_number  (results.frame_number)
);

`default_nettype wire
